[src/rllt_pkg.sv]
// Package for the run-length line table: sizes, payload structs and codes.
// Used by every module of the block; depends on nothing.
package rllt_pkg;

	// Storage sizes.
	localparam int BYTE_DEPTH = 4096;
	localparam int RUN_DEPTH  = 256;
	localparam int BYTE_AW    = $clog2(BYTE_DEPTH);
	localparam int RUN_AW     = $clog2(RUN_DEPTH);
	localparam int RUN_CW     = RUN_AW + 1;

	// Field widths fixed by the interface.
	localparam int COUNT_W = 13;
	localparam int LINE_W  = 16;

	// Command queue between the front and the back.
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	// Action codes of the request.
	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_LOOKUP = 2'd1;
	localparam logic [1:0] ACT_REWIND = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// Status codes of the response.
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BYTES_FULL = 2'd1;
	localparam logic [1:0] STATUS_RUNS_FULL  = 2'd2;
	localparam logic [1:0] STATUS_BAD_POS    = 2'd3;

	// Request and response payloads.
	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        data_value;
		logic [2:0]         data_bytes;
		logic [LINE_W-1:0]  line_number;
		logic [COUNT_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [LINE_W-1:0]  line_out;
		logic [7:0]         byte_out;
		logic [COUNT_W-1:0] count_out;
	} rsp_t;

	// Command class decided by the front.
	typedef enum logic [1:0] {
		K_APPEND,
		K_LOOKUP,
		K_REWIND,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        data_value;
		logic [2:0]         data_bytes;
		logic [LINE_W-1:0]  line_number;
		logic [COUNT_W-1:0] position;
	} cmd_t;

endpackage

[src/rllt_front.sv]
// Front of the run-length line table: accepts requests and classifies them.
// Depends on rllt_pkg; feeds the command queue.
module rllt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rllt_pkg::req_t req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output rllt_pkg::cmd_t cmd
);
	import rllt_pkg::*;

	logic  vld_s1;
	cmd_t  cmd_s1;
	cmd_t  cls;

	// Classification: a bad byte count or the unused action does nothing.
	always_comb begin
		cls.data_value  = req.data_value;
		cls.data_bytes  = req.data_bytes;
		cls.line_number = req.line_number;
		cls.position    = req.position;
		unique case (req.action)
			ACT_APPEND: begin
				if (req.data_bytes == 3'd1 || req.data_bytes == 3'd2 ||
				    req.data_bytes == 3'd4) begin
					cls.kind = K_APPEND;
				end else begin
					cls.kind = K_NOP;
				end
			end
			ACT_LOOKUP: cls.kind = K_LOOKUP;
			ACT_REWIND: cls.kind = K_REWIND;
			ACT_NONE:   cls.kind = K_NOP;
			default:    cls.kind = K_NOP;
		endcase
	end

	assign req_ready = !vld_s1 || cmd_ready;

	// Stage register toward the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_s1 <= cls;
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

endmodule

[src/rllt_queue.sv]
// Short command queue that decouples the front from the back.
// Depends on rllt_pkg for the command type and depth.
module rllt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  rllt_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output rllt_pkg::cmd_t pop_cmd
);
	import rllt_pkg::*;

	cmd_t            slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q;
	logic [Q_AW-1:0] rp_q;
	logic [Q_AW:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = cnt_q != (Q_AW+1)'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = slot_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + Q_AW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (Q_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (Q_AW+1)'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_cmd;
		end
	end

endmodule

[src/rllt_back.sv]
// Back of the run-length line table: byte store, run table and the walk.
// Depends on rllt_pkg; takes commands from the queue, drives the response.
module rllt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  rllt_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rllt_pkg::rsp_t rsp
);
	import rllt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_APPEND = 4'b0010,
		S_WALK   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	// Control state.
	state_t             state_q, state_d;
	logic [COUNT_W-1:0] byte_total_q, byte_total_d;
	logic [RUN_CW-1:0]  run_total_q, run_total_d;
	logic [LINE_W-1:0]  last_line_q, last_line_d;
	logic [COUNT_W-1:0] last_len_q, last_len_d;
	logic [COUNT_W-1:0] len0_q, len0_d;
	logic               rsp_valid_q, rsp_valid_d;
	logic               dv_q, dv_d;

	// Payload registers.
	cmd_t               cmd_q, cmd_d;
	rsp_t               res_q, res_d;
	rsp_t               rsp_q, rsp_d;
	logic [COUNT_W-1:0] ap_base_q, ap_base_d;
	logic [2:0]         ap_k_q, ap_k_d;
	logic [RUN_CW-1:0]  idx_q, idx_d;
	logic [RUN_AW-1:0]  dix_q, dix_d;
	logic [COUNT_W-1:0] sum_q, sum_d;

	// Memories and their ports.
	logic [7:0]         byte_mem [BYTE_DEPTH];
	logic [LINE_W-1:0]  line_mem [RUN_DEPTH];
	logic [COUNT_W-1:0] len_mem  [RUN_DEPTH];
	logic [7:0]         byte_rd_q;
	logic [LINE_W-1:0]  line_rd_q;
	logic [COUNT_W-1:0] len_rd_q;
	logic               byte_we, byte_re, len_we, line_we;
	logic [BYTE_AW-1:0] byte_wa;
	logic [7:0]         byte_wd;
	logic [RUN_AW-1:0]  len_wa, line_wa, rd_run_addr, last_idx;
	logic [COUNT_W-1:0] len_wd;
	logic [LINE_W-1:0]  line_wd;

	// Helpers for the dispatch and the walk.
	logic [COUNT_W:0]   grown_total;
	logic               same_line, bytes_full, runs_full;
	logic [COUNT_W-1:0] run_len, new_sum, cut_len, ap_addr;
	logic [LINE_W-1:0]  run_ln;
	logic [2:0]         ap_k_next;

	assign cmd_ready   = (state_q == S_IDLE);
	assign last_idx    = RUN_AW'(run_total_q - RUN_CW'(1));
	assign grown_total = {1'b0, byte_total_q} + {{(COUNT_W-2){1'b0}}, cmd.data_bytes};
	assign same_line   = (last_line_q == cmd.line_number);
	assign bytes_full  = grown_total > (COUNT_W+1)'(BYTE_DEPTH);
	assign runs_full   = !same_line && (run_total_q >= RUN_CW'(RUN_DEPTH));
	assign run_len     = (dix_q == '0) ? len0_q : len_rd_q;
	assign run_ln      = (dix_q == '0) ? LINE_W'(1) : line_rd_q;
	assign new_sum     = sum_q + run_len;
	assign cut_len     = cmd_q.position - sum_q;
	assign ap_addr     = ap_base_q + {{(COUNT_W-3){1'b0}}, ap_k_q};
	assign ap_k_next   = ap_k_q + 3'd1;
	assign rd_run_addr = (state_q == S_WALK) ? idx_q[RUN_AW-1:0] : '0;

	// Next-state logic of the sequencer.
	always_comb begin
		state_d      = state_q;
		byte_total_d = byte_total_q;
		run_total_d  = run_total_q;
		last_line_d  = last_line_q;
		last_len_d   = last_len_q;
		len0_d       = len0_q;
		rsp_valid_d  = rsp_valid_q;
		dv_d         = dv_q;
		cmd_d        = cmd_q;
		res_d        = res_q;
		rsp_d        = rsp_q;
		ap_base_d    = ap_base_q;
		ap_k_d       = ap_k_q;
		idx_d        = idx_q;
		dix_d        = dix_q;
		sum_d        = sum_q;
		byte_we      = 1'b0;
		byte_re      = 1'b0;
		byte_wa      = ap_addr[BYTE_AW-1:0];
		byte_wd      = cmd_q.data_value[{ap_k_q[1:0], 3'b000} +: 8];
		len_we       = 1'b0;
		len_wa       = last_idx;
		len_wd       = last_len_q;
		line_we      = 1'b0;
		line_wa      = run_total_q[RUN_AW-1:0];
		line_wd      = cmd.line_number;

		if (rsp_valid_q && rsp_ready) begin
			rsp_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_d = cmd;
					res_d = '0;
					idx_d = RUN_CW'(1);
					dix_d = '0;
					dv_d  = 1'b1;
					sum_d = '0;
					unique case (cmd.kind)
						K_APPEND: begin
							if (bytes_full) begin
								res_d.status = STATUS_BYTES_FULL;
								state_d      = S_FINISH;
							end else if (runs_full) begin
								res_d.status = STATUS_RUNS_FULL;
								state_d      = S_FINISH;
							end else begin
								byte_total_d = grown_total[COUNT_W-1:0];
								ap_base_d    = byte_total_q;
								ap_k_d       = 3'd0;
								state_d      = S_APPEND;
								len_we       = 1'b1;
								if (same_line) begin
									// The last run grows.
									last_len_d = last_len_q +
										{{(COUNT_W-3){1'b0}}, cmd.data_bytes};
									len_wa     = last_idx;
									len_wd     = last_len_d;
									if (last_idx == '0) begin
										len0_d = last_len_d;
									end
								end else begin
									// A new run opens after the last one.
									line_we     = 1'b1;
									len_wa      = run_total_q[RUN_AW-1:0];
									len_wd      = {{(COUNT_W-3){1'b0}}, cmd.data_bytes};
									last_line_d = cmd.line_number;
									last_len_d  = len_wd;
									run_total_d = run_total_q + RUN_CW'(1);
								end
							end
						end
						K_LOOKUP: begin
							if (cmd.position >= byte_total_q) begin
								res_d.status = STATUS_BAD_POS;
								state_d      = S_FINISH;
							end else begin
								byte_re = 1'b1;
								state_d = S_WALK;
							end
						end
						K_REWIND: begin
							if (cmd.position > byte_total_q) begin
								res_d.status = STATUS_BAD_POS;
								state_d      = S_FINISH;
							end else begin
								state_d = S_WALK;
							end
						end
						K_NOP: begin
							state_d = S_FINISH;
						end
						default: begin
							state_d = S_FINISH;
						end
					endcase
				end
			end
			S_APPEND: begin
				// One byte a cycle, least significant first.
				byte_we = 1'b1;
				ap_k_d  = ap_k_next;
				if (ap_k_next == cmd_q.data_bytes) begin
					state_d = S_FINISH;
				end
			end
			S_WALK: begin
				// Reads stream one run a cycle; the read data is registered, and dix_q names its run.
				idx_d = idx_q + RUN_CW'(1);
				dix_d = idx_q[RUN_AW-1:0];
				dv_d  = idx_q < run_total_q;
				if (!dv_q) begin
					if (cmd_q.kind == K_LOOKUP) begin
						res_d.status = STATUS_BAD_POS;
					end else begin
						byte_total_d = cmd_q.position;
					end
					state_d = S_FINISH;
				end else begin
					sum_d = new_sum;
					if (cmd_q.kind == K_LOOKUP) begin
						if (new_sum > cmd_q.position) begin
							res_d.line_out = run_ln;
							res_d.byte_out = byte_rd_q;
							state_d        = S_FINISH;
						end
					end else if (new_sum >= cmd_q.position) begin
						// Trim the run holding the cut and drop the later ones.
						byte_total_d = cmd_q.position;
						len_we       = 1'b1;
						len_wa       = dix_q;
						len_wd       = cut_len;
						if (dix_q == '0) begin
							len0_d = cut_len;
						end
						run_total_d = {1'b0, dix_q} + RUN_CW'(1);
						last_line_d = run_ln;
						last_len_d  = cut_len;
						state_d     = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_d           = res_q;
					rsp_d.count_out = byte_total_q;
					rsp_valid_d     = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			byte_total_q <= '0;
			run_total_q  <= RUN_CW'(1);
			last_line_q  <= LINE_W'(1);
			last_len_q   <= '0;
			len0_q       <= '0;
			rsp_valid_q  <= 1'b0;
			dv_q         <= 1'b0;
		end else begin
			state_q      <= state_d;
			byte_total_q <= byte_total_d;
			run_total_q  <= run_total_d;
			last_line_q  <= last_line_d;
			last_len_q   <= last_len_d;
			len0_q       <= len0_d;
			rsp_valid_q  <= rsp_valid_d;
			dv_q         <= dv_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		res_q     <= res_d;
		rsp_q     <= rsp_d;
		ap_base_q <= ap_base_d;
		ap_k_q    <= ap_k_d;
		idx_q     <= idx_d;
		dix_q     <= dix_d;
		sum_q     <= sum_d;
	end

	// Byte store: one write or one registered read a cycle.
	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[byte_wa] <= byte_wd;
		end
		if (byte_re) begin
			byte_rd_q <= byte_mem[cmd.position[BYTE_AW-1:0]];
		end
	end

	// Run table: line and length of each run, read at the walk address.
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[len_wa] <= len_wd;
		end
		if (line_we) begin
			line_mem[line_wa] <= line_wd;
		end
		len_rd_q  <= len_mem[rd_run_addr];
		line_rd_q <= line_mem[rd_run_addr];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A checked run during the walk is always one of the runs in use.
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && dv_q) |-> ({1'b0, dix_q} < run_total_q))
		else $error("walk checks a run beyond the table");

	// Leaving the finish state always presents a response.
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |=> (state_q == S_FINISH || rsp_valid_q))
		else $error("finish left without a response");

	// The byte counter of an append stays below its byte count.
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |-> (ap_k_q < cmd_q.data_bytes))
		else $error("append wrote too many bytes");

	// With a single run, the cached last run is the first run.
	a_single_run: assert property (@(posedge clk) disable iff (!arst_n)
		(run_total_q == RUN_CW'(1)) |-> (last_len_q == len0_q && last_line_q == LINE_W'(1)))
		else $error("cached last run disagrees with the first run");

endmodule

[src/run_length_line_table_unit.sv]
// Top level of the run-length line table: front, command queue and back.
// Depends on rllt_pkg, rllt_front, rllt_queue and rllt_back.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------
//  req      | in        | req_valid/req_ready | action, data, bytes, line, pos
//  rsp      | out       | rsp_valid/rsp_ready | status, line, byte, count
//
// An append writes its bytes one at a time through the byte store write port.
// A lookup or rewind walks the run table one run a cycle through its read port.
// Reset clears the counters and the run cache at once; no clearing pass runs.
// The front and the queue keep taking requests while the back works or while
// a response waits for rsp_ready, until the queue and the front stage are full.
module run_length_line_table_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rllt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rllt_pkg::rsp_t rsp
);
	import rllt_pkg::*;

	logic fq_valid, fq_ready, qb_valid, qb_ready;
	cmd_t fq_cmd, qb_cmd;

	// Accept and classify.
	rllt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd_valid (fq_valid),
		.cmd_ready (fq_ready),
		.cmd       (fq_cmd)
	);

	// Decoupling queue.
	rllt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_cmd   (fq_cmd),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_cmd    (qb_cmd)
	);

	// Execute against the stores.
	rllt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
